// File: rtl/core/sfd_pkg.sv
// Shared types and constants of the serial bus frame decoder.
// Used by every module in rtl/core; depends on nothing.
package sfd_pkg;

  // Frame geometry: start byte, 22 channel bytes, flag byte, end byte
  localparam int FRAME_BYTES   = 25;
  localparam int STORE_BYTES   = FRAME_BYTES - 2;
  localparam int PAYLOAD_BYTES = FRAME_BYTES - 3;
  localparam int STORE_W       = STORE_BYTES * 8;
  localparam int PAYLOAD_W     = PAYLOAD_BYTES * 8;
  localparam int POS_W         = $clog2(STORE_BYTES + 1);

  // Channels
  localparam int CHANNELS      = 16;
  localparam int CH_W          = 11;
  localparam int CH_IDX_W      = $clog2(CHANNELS);
  localparam int ZERO_CHECK_CH = 8;
  localparam int ZERO_CNT_W    = $clog2(ZERO_CHECK_CH + 1);

  // Flag byte bit positions
  localparam int FLAG_CH17_BIT     = 7;
  localparam int FLAG_CH18_BIT     = 6;
  localparam int FLAG_LOST_BIT     = 5;
  localparam int FLAG_FAILSAFE_BIT = 4;

  // Frame queue between parser and result sequencer
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Port widths
  localparam int IN_DATA_W  = 8;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 8;
  localparam int LIMIT_W    = 4;
  localparam int OUT_FIELD_W = CH_IDX_W + CH_W + 5;
  localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

  // Reset values of the configuration registers
  localparam logic [7:0]         START_BYTE_RST = 8'h0f;
  localparam logic [7:0]         END_BYTE_RST   = 8'h00;
  localparam logic [LIMIT_W-1:0] ZERO_LIMIT_RST = 4'd4;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_START_BYTE = 2'd0,
    CFG_END_BYTE   = 2'd1,
    CFG_ZERO_LIMIT = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_END     = 2'd2
  } phase_e;

  // One accepted frame, as queued for the sequencer
  typedef struct packed {
    logic [PAYLOAD_W-1:0] payload;
    logic                 dig_ch17;
    logic                 dig_ch18;
    logic                 frame_lost;
    logic                 failsafe;
    logic                 frame_valid;
  } frame_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

// File: rtl/core/sfd_front.sv
// Byte parser of the frame decoder: hunts for the start byte, collects
// the frame, checks the end byte and pushes whole frames. Uses sfd_pkg.
module sfd_front import sfd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  byte_valid_i,
  output logic                  byte_ready_o,
  input  logic [IN_DATA_W-1:0]  byte_i,
  input  fifo_status_t          fifo_status_i,
  output logic                  push_o,
  output frame_t                frame_o
);

  logic [7:0]         start_byte_q;
  logic [7:0]         end_byte_q;
  logic [LIMIT_W-1:0] zero_limit_q;

  phase_e             phase_q, phase_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [STORE_W-1:0] store_q, store_d;

  logic               byte_fire;
  logic [7:0]         flags;
  logic [ZERO_CNT_W-1:0] zeros;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q <= START_BYTE_RST;
      end_byte_q   <= END_BYTE_RST;
      zero_limit_q <= ZERO_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_START_BYTE: start_byte_q <= cfg_wdata_i;
        CFG_END_BYTE:   end_byte_q   <= cfg_wdata_i;
        CFG_ZERO_LIMIT: zero_limit_q <= cfg_wdata_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Stall only when a closing byte could find the queue full
  assign byte_ready_o = !((phase_q == PH_END) && fifo_status_i.full);
  assign byte_fire    = byte_valid_i && byte_ready_o;

  // Parser next state
  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    store_d = store_q;
    push_o  = 1'b0;
    if (byte_fire) begin
      case (phase_q)
        PH_HUNT: begin
          pos_d = '0;
          if (byte_i == start_byte_q) begin
            phase_d = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          // shift in: oldest byte ends at the low end
          store_d = {byte_i, store_q[STORE_W-1:8]};
          pos_d   = pos_q + POS_W'(1);
          if (pos_q == POS_W'(STORE_BYTES - 1)) begin
            phase_d = PH_END;
          end
        end
        PH_END: begin
          phase_d = PH_HUNT;
          push_o  = (byte_i == end_byte_q);
        end
        default: begin
          phase_d = PH_HUNT;
          pos_d   = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      pos_q   <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
    end
  end

  // Frame bytes hold no reset; every byte is written before it is used
  always_ff @(posedge clk_i) begin
    store_q <= store_d;
  end

  // Count zero-valued channels among the checked ones
  always_comb begin
    zeros = '0;
    for (int c = 0; c < ZERO_CHECK_CH; c++) begin
      if (store_q[c*CH_W +: CH_W] == '0) begin
        zeros = zeros + ZERO_CNT_W'(1);
      end
    end
  end

  assign flags = store_q[STORE_W-1 -: 8];

  // Build the frame record
  always_comb begin
    frame_o.payload     = store_q[PAYLOAD_W-1:0];
    frame_o.dig_ch17    = flags[FLAG_CH17_BIT];
    frame_o.dig_ch18    = flags[FLAG_CH18_BIT];
    frame_o.frame_lost  = flags[FLAG_LOST_BIT];
    frame_o.failsafe    = flags[FLAG_FAILSAFE_BIT];
    frame_o.frame_valid = !flags[FLAG_LOST_BIT] && !flags[FLAG_FAILSAFE_BIT]
                          && (LIMIT_W'(zeros) <= zero_limit_q);
  end

endmodule

// File: rtl/core/sfd_frame_fifo.sv
// Short frame queue between the parser and the result sequencer.
// Uses sfd_pkg for the frame record and depth.
module sfd_frame_fifo import sfd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  frame_t       frame_i,
  input  logic         pop_i,
  output frame_t       frame_o,
  output fifo_status_t status_o
);

  frame_t                mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0] count_q;

  function automatic logic [FIFO_PTR_W-1:0] ptr_inc(input logic [FIFO_PTR_W-1:0] p);
    if (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) begin
      return '0;
    end
    return p + FIFO_PTR_W'(1);
  endfunction

  assign status_o.full  = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign frame_o        = mem_q[rd_ptr_q];

  // Store the pushed frame
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= frame_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + FIFO_CNT_W'(1);
        2'b01:   count_q <= count_q - FIFO_CNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// File: rtl/core/sfd_back.sv
// Result sequencer: walks the head frame one channel per word and drives
// the registered output stream. Uses sfd_pkg.
module sfd_back import sfd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  frame_t                frame_i,
  input  fifo_status_t          fifo_status_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [OUT_DATA_W-1:0] out_data_o,
  output logic                  out_last_o
);

  logic [CH_IDX_W-1:0]   ch_q, ch_d;
  logic                  valid_q, valid_d;
  logic [OUT_DATA_W-1:0] data_q, data_d;
  logic                  last_q, last_d;
  logic                  load;
  logic [CH_W-1:0]       ch_value;
  logic                  ch_last;

  assign ch_value = frame_i.payload[ch_q*CH_W +: CH_W];
  assign ch_last  = (ch_q == CH_IDX_W'(CHANNELS - 1));
  assign load     = (!valid_q || out_ready_i) && !fifo_status_i.empty;
  assign pop_o    = load && ch_last;

  // Next output word and channel counter
  always_comb begin
    ch_d    = ch_q;
    valid_d = valid_q;
    data_d  = data_q;
    last_d  = last_q;
    if (!valid_q || out_ready_i) begin
      valid_d = 1'b0;
    end
    if (load) begin
      valid_d = 1'b1;
      last_d  = ch_last;
      ch_d    = ch_last ? '0 : ch_q + CH_IDX_W'(1);
      data_d  = OUT_DATA_W'({frame_i.frame_valid, frame_i.failsafe, frame_i.frame_lost,
                             frame_i.dig_ch18, frame_i.dig_ch17, ch_value, ch_q});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q    <= '0;
      valid_q <= 1'b0;
    end else begin
      ch_q    <= ch_d;
      valid_q <= valid_d;
    end
  end

  // Output payload holds no reset
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    last_q <= last_d;
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;
  assign out_last_o  = last_q;

endmodule

// File: rtl/core/sbus_frame_decoder_unit.sv
// Top level of the serial bus frame decoder: parser, frame queue and
// result sequencer. Depends on sfd_pkg, sfd_front, sfd_frame_fifo, sfd_back.

// The decoder takes one received byte per cycle on the slave stream unless it
// stalls. After the start byte it collects 22 channel bytes and the flag byte;
// if the next byte equals the end byte the frame goes into a two-frame queue,
// and the sequencer emits sixteen words, channels 0 to 15 in order, one per
// cycle unless the receiver holds them off, tlast on channel 15. A frame with
// a wrong end byte is dropped and the parser hunts again. Input stalls only
// when an end byte arrives while both queued frames still wait for the
// sequencer. Config is to be written through cfg_we_i / cfg_addr_i /
// cfg_wdata_i by the user while the block idles; the block does not enforce it.
module sbus_frame_decoder_unit import sfd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // received bytes
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // [7:0] rx_byte
  // channel results
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [3:0] channel_index, [14:4] channel_value, [15] digital_ch17,
  // [16] digital_ch18, [17] frame_lost, [18] failsafe, [19] frame_valid,
  // [23:20] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tlast   // last_channel
);

  frame_t       push_frame;
  frame_t       head_frame;
  logic         push;
  logic         pop;
  fifo_status_t fifo_status;

  sfd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .byte_valid_i (s_axis_tvalid),
    .byte_ready_o (s_axis_tready),
    .byte_i       (s_axis_tdata),
    .fifo_status_i(fifo_status),
    .push_o       (push),
    .frame_o      (push_frame)
  );

  sfd_frame_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .frame_i (push_frame),
    .pop_i   (pop),
    .frame_o (head_frame),
    .status_o(fifo_status)
  );

  sfd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .frame_i      (head_frame),
    .fifo_status_i(fifo_status),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata),
    .out_last_o   (m_axis_tlast)
  );

`ifndef SYNTHESIS
  // tlast marks exactly the word of the last channel
  a_last_on_final_channel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[CH_IDX_W-1:0] ==
                                        CH_IDX_W'(CHANNELS - 1))))
    else $error("tlast does not match the last channel");

  // input stalls only on a full frame queue
  a_stall_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> fifo_status.full)
    else $error("input stalled with room in the frame queue");

  // never push into a full queue
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !fifo_status.full)
    else $error("frame pushed into a full queue");

  // a popped frame always has its last word offered by the sequencer next cycle
  a_pop_gives_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> (m_axis_tvalid && m_axis_tlast))
    else $error("frame popped without a last word");
`endif

endmodule

// File: verif/tb_sbus_frame_decoder_unit.sv
// Self-checking testbench for sbus_frame_decoder_unit: drives received bytes, predicts every
// channel word from its own frame parser and compares it with what the block emits.
// Depends on sfd_pkg and the RTL under rtl/core.
module tb_sbus_frame_decoder_unit;
  import sfd_pkg::*;

  // One expected channel word
  typedef struct packed {
    logic [3:0]  index;
    logic [10:0] value;
    logic        ch17;
    logic        ch18;
    logic        lost;
    logic        failsafe;
    logic        valid;
    logic        last;
  } chan_word_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_ADDR_W-1:0] cfg_addr_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;   // [7:0] rx_byte
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  // [3:0] channel_index, [14:4] channel_value, [15] digital_ch17, [16] digital_ch18,
  // [17] frame_lost, [18] failsafe, [19] frame_valid, [23:20] zero
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;   // last_channel

  sbus_frame_decoder_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // Shadow of the decoder: registers, parser state and frame buffer
  logic [7:0]  start_reg;
  logic [7:0]  end_reg;
  logic [3:0]  limit_reg;
  phase_e      parse_ph;
  logic [4:0]  byte_pos;
  logic [7:0]  frame_buf [FRAME_BYTES];

  chan_word_t  pending_words [$];
  chan_word_t  want_word;
  int          error_count = 0;
  int          bytes_sent  = 0;

  // Traffic shaping shared with the receiver process
  bit          tx_idle_on;
  bit          rx_idle_on;
  int          hold_cycles;

  // Channel values of the next frame to send
  logic [10:0] frame_ch [CHANNELS];

  function automatic logic [7:0] buf_at(int pos);
    return (pos < FRAME_BYTES) ? frame_buf[pos] : 8'h00;
  endfunction

  // Advance the shadow parser by one byte; queue sixteen words on a closed frame
  function automatic void decode_rx_byte(logic [7:0] b);
    int          zeros;
    int          base;
    int          bitpos;
    logic [7:0]  flags;
    logic [23:0] span;
    logic [23:0] shifted;
    logic [10:0] vals [CHANNELS];
    logic        frame_ok;
    chan_word_t  w;
    case (parse_ph)
      PH_PAYLOAD: begin
        byte_pos = byte_pos + 5'd1;
        if (byte_pos < FRAME_BYTES) frame_buf[byte_pos] = b;
        if (byte_pos >= FRAME_BYTES - 2) parse_ph = PH_END;
      end
      PH_END: begin
        parse_ph = PH_HUNT;
        if (b == end_reg) begin
          byte_pos = byte_pos + 5'd1;
          if (byte_pos < FRAME_BYTES) frame_buf[byte_pos] = b;
          zeros = 0;
          for (int c = 0; c < CHANNELS; c++) begin
            bitpos  = c * CH_W;
            base    = 1 + (bitpos >> 3);
            span    = {buf_at(base + 2), buf_at(base + 1), buf_at(base)};
            shifted = span >> (bitpos & 7);
            vals[c] = shifted[10:0];
            if (c < ZERO_CHECK_CH && vals[c] == 11'd0) zeros++;
          end
          flags    = buf_at(FRAME_BYTES - 2);
          frame_ok = (flags[FLAG_LOST_BIT] == 1'b0) && (flags[FLAG_FAILSAFE_BIT] == 1'b0) &&
                     (zeros <= limit_reg);
          for (int c = 0; c < CHANNELS; c++) begin
            w.index    = c[3:0];
            w.value    = vals[c];
            w.ch17     = flags[FLAG_CH17_BIT];
            w.ch18     = flags[FLAG_CH18_BIT];
            w.lost     = flags[FLAG_LOST_BIT];
            w.failsafe = flags[FLAG_FAILSAFE_BIT];
            w.valid    = frame_ok;
            w.last     = (c == CHANNELS - 1);
            pending_words.push_back(w);
          end
        end
      end
      default: begin
        // Hunting: clear the buffer, open a frame on the start byte
        parse_ph = PH_HUNT;
        byte_pos = 5'd0;
        for (int i = 0; i < FRAME_BYTES; i++) frame_buf[i] = 8'h00;
        if (b == start_reg) begin
          parse_ph     = PH_PAYLOAD;
          frame_buf[0] = b;
        end
      end
    endcase
  endfunction

  function automatic void note_failure(string msg);
    error_count++;
    if (error_count <= 10) $display("MISMATCH at %0t: %s", $realtime, msg);
  endfunction

  function automatic void check_field(string name, logic [10:0] want, logic [10:0] got);
    if (want !== got)
      note_failure($sformatf("%s expected %0h actual %0h", name, want, got));
  endfunction

  // Compare every accepted word with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_words.size() == 0) begin
        note_failure($sformatf("unexpected word %h tlast %b", m_axis_tdata, m_axis_tlast));
      end else begin
        want_word = pending_words.pop_front();
        check_field("channel_index", 11'(want_word.index), 11'(m_axis_tdata[3:0]));
        check_field("channel_value", want_word.value, m_axis_tdata[14:4]);
        check_field("digital_ch17", 11'(want_word.ch17), 11'(m_axis_tdata[15]));
        check_field("digital_ch18", 11'(want_word.ch18), 11'(m_axis_tdata[16]));
        check_field("frame_lost", 11'(want_word.lost), 11'(m_axis_tdata[17]));
        check_field("failsafe", 11'(want_word.failsafe), 11'(m_axis_tdata[18]));
        check_field("frame_valid", 11'(want_word.valid), 11'(m_axis_tdata[19]));
        check_field("last_channel", 11'(want_word.last), 11'(m_axis_tlast));
      end
    end
  end

  // Receiver: random stalls per word, plus a long hold-off on request
  initial begin
    int stall;
    int n;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_cycles > 0) begin
        n           = hold_cycles;
        hold_cycles = 0;
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      stall = rx_idle_on ? $urandom_range(0, 12) : 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid && hold_cycles == 0);
    end
  end

  // Offer one byte after a random gap and hold it until taken
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    decode_rx_byte(b);
    bytes_sent++;
  endtask

  // Send start byte, packed channels from frame_ch, flag byte and closing byte
  task automatic send_frame(input logic [7:0] flags, input logic [7:0] closing);
    logic [PAYLOAD_W-1:0] packed_ch;
    for (int c = 0; c < CHANNELS; c++) packed_ch[c*CH_W +: CH_W] = frame_ch[c];
    send_byte(start_reg);
    for (int i = 0; i < PAYLOAD_BYTES; i++) send_byte(packed_ch[i*8 +: 8]);
    send_byte(flags);
    send_byte(closing);
  endtask

  // Drop tvalid, let every expected word drain, then let the block settle
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [7:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_START_BYTE: start_reg = val;
      CFG_END_BYTE:   end_reg   = val;
      CFG_ZERO_LIMIT: limit_reg = val[3:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Zero the first low_zeros of channels 0..7, optionally all of 8..15
  function automatic void fill_channels(int low_zeros, bit high_zero);
    for (int c = 0; c < CHANNELS; c++) begin
      if (c < ZERO_CHECK_CH) frame_ch[c] = (c < low_zeros) ? 11'd0 : 11'($urandom_range(1, 2047));
      else frame_ch[c] = high_zero ? 11'd0 : 11'($urandom_range(1, 2047));
    end
  endfunction

  // Mix of zeros, full scale and random values so the zero count wanders
  function automatic void fill_random_channels();
    int r;
    for (int c = 0; c < CHANNELS; c++) begin
      r = $urandom_range(0, 7);
      if (r < 2) frame_ch[c] = 11'd0;
      else if (r == 2) frame_ch[c] = 11'h7FF;
      else frame_ch[c] = 11'($urandom_range(0, 2047));
    end
  endfunction

  task automatic send_noise(input int count);
    logic [7:0] b;
    for (int i = 0; i < count; i++) begin
      b = 8'($urandom_range(0, 255));
      if (b == start_reg && $urandom_range(0, 1) == 1) b = ~b;
      send_byte(b);
    end
  endtask

  task automatic test_default_frame();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    for (int c = 0; c < CHANNELS; c++) frame_ch[c] = 11'h7FF;
    send_frame(8'hC0, end_reg);
    for (int c = 0; c < CHANNELS; c++) frame_ch[c] = c[0] ? 11'h2AA : 11'h555;
    send_frame(8'h80, end_reg);
  endtask

  task automatic test_fault_flags();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    fill_channels(0, 1'b0);
    send_frame(8'h20, end_reg);
    fill_channels(0, 1'b0);
    send_frame(8'h10, end_reg);
  endtask

  task automatic test_zero_limit();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b0;
    // zeros in channels 8..15 do not count
    fill_channels(4, 1'b1);
    send_frame(8'h00, end_reg);
    fill_channels(5, 1'b0);
    send_frame(8'h00, end_reg);
    wait_idle();
    // a limit above eight leaves only the fault flags
    write_reg(CFG_ZERO_LIMIT, 8'd15);
    fill_channels(8, 1'b1);
    send_frame(8'h00, end_reg);
    wait_idle();
    write_reg(CFG_ZERO_LIMIT, 8'd4);
  endtask

  task automatic test_bad_end();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    // closing byte equal to the start byte must not reopen a frame
    fill_channels(0, 1'b0);
    send_frame(8'h00, start_reg);
    fill_channels(2, 1'b0);
    send_frame(8'h80, end_reg);
    send_byte(8'hA5);
    send_byte(8'h00);
  endtask

  task automatic test_start_end_extremes();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b1;
    wait_idle();
    write_reg(CFG_START_BYTE, 8'h00);
    write_reg(CFG_END_BYTE, 8'hFF);
    send_byte(8'hFF);
    send_byte(8'h01);
    fill_random_channels();
    send_frame(8'h40, end_reg);
    wait_idle();
    // later frames open on 0xFF
    write_reg(CFG_START_BYTE, 8'hFF);
    write_reg(CFG_END_BYTE, 8'h00);
    send_byte(8'h00);
    wait_idle();
  endtask

  task automatic test_backpressure();
    tx_idle_on  = 1'b0;
    rx_idle_on  = 1'b0;
    hold_cycles = 400;
    for (int f = 0; f < 3; f++) begin
      fill_channels(0, 1'b0);
      send_frame(8'($urandom_range(0, 255)), end_reg);
    end
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int         frames;
    int         kind;
    logic [7:0] flags;
    frames = 0;
    // fill up the byte budget of the whole run
    while (bytes_sent < 370) begin
      // reconfigure every other frame, only once the block has drained
      if (frames % 2 == 1) begin
        wait_idle();
        write_reg(CFG_START_BYTE, 8'($urandom_range(0, 255)));
        write_reg(CFG_END_BYTE, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 9) == 0) write_reg(CFG_ZERO_LIMIT, 8'($urandom_range(9, 15)));
        else write_reg(CFG_ZERO_LIMIT, 8'($urandom_range(0, 8)));
      end
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 9);
      fill_random_channels();
      if (kind == 0) begin
        send_frame(8'($urandom_range(0, 255)), end_reg ^ 8'($urandom_range(1, 255)));
      end else if (kind == 1) begin
        send_noise($urandom_range(1, 4));
      end else begin
        flags = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 3) != 0) flags[5:4] = 2'b00;
        send_frame(flags, end_reg);
      end
      frames++;
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = CFG_START_BYTE;
    cfg_wdata_i   = 8'h00;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    tx_idle_on    = 1'b0;
    rx_idle_on    = 1'b0;
    hold_cycles   = 0;
    start_reg     = START_BYTE_RST;
    end_reg       = END_BYTE_RST;
    limit_reg     = ZERO_LIMIT_RST;
    parse_ph      = PH_HUNT;
    byte_pos      = 5'd0;
    for (int i = 0; i < FRAME_BYTES; i++) frame_buf[i] = 8'h00;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_frame();
    test_fault_flags();
    test_zero_limit();
    test_bad_end();
    test_start_end_extremes();
    test_backpressure();
    test_random_traffic();
    wait_idle();

    if (error_count == 0) begin
      $display("tb_sbus_frame_decoder_unit passed");
    end else begin
      $display("tb_sbus_frame_decoder_unit failed");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #2000000;
    $display("tb_sbus_frame_decoder_unit failed");
    $finish;
  end

endmodule
